[rtl/frustum_aabb_cull_core_assert.svh]
// ---------------------------------------------------------------------------
// Frustum box cull assertion macros
// Shared concurrent assertion forms used by the culling core.
// ---------------------------------------------------------------------------
`ifndef FRUSTUM_AABB_CULL_CORE_ASSERT_SVH
`define FRUSTUM_AABB_CULL_CORE_ASSERT_SVH

// Antecedent holds in a cycle, consequent holds in the same cycle.
`define FAC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent holds in a cycle, consequent holds in the next cycle.
`define FAC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/fac_pkg.sv]
// ---------------------------------------------------------------------------
// Frustum box cull package
// Widths, command codes and plane coefficient helper.
// ---------------------------------------------------------------------------
package fac_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NUM_PLANES = 6;
    localparam int NUM_CORNER_AXES = 3;
    localparam int ELEM_W = 32;
    localparam int COEF_W = ELEM_W + 1;
    localparam int PROD_W = COEF_W + ELEM_W;
    localparam int SUM_W = PROD_W + 3;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEST = 1'b1;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0] sum_t;

    // Planes in order left, right, bottom, top, near, far.
    function automatic coef_t plane_coef(input logic [2:0] k, input elem_t r0,
                                         input elem_t r1, input elem_t r2,
                                         input elem_t r3);
        coef_t a0;
        coef_t a1;
        coef_t a2;
        coef_t a3;
        coef_t res;
        a0 = coef_t'(r0);
        a1 = coef_t'(r1);
        a2 = coef_t'(r2);
        a3 = coef_t'(r3);
        case (k)
            3'd0: res = a3 + a0;
            3'd1: res = a3 - a0;
            3'd2: res = a3 + a1;
            3'd3: res = a3 - a1;
            3'd4: res = a2;
            3'd5: res = a3 - a2;
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

[rtl/frustum_aabb_cull_core.sv]
// ---------------------------------------------------------------------------
// Frustum box culling core
// Loads view-projection rows and tests axis-aligned boxes against six planes.
// ---------------------------------------------------------------------------
// Requests arrive on the s_axis channel. tuser 0 is a row load and tuser 1
// is a box test. Every request gives one response on m_axis: tuser carries
// 1 for a test and 0 for a load acknowledge, and tdata bit 0 is the visible
// flag, which is 0 on loads.
// A request passes stage one, stage two and the output register; one request
// is accepted every cycle while nothing stalls. For each plane only the corner
// with the largest value is evaluated, so six planes of three multipliers each
// do the whole test in one pass; the multiplier stage sets the clock path.
// A load changes the matrix at its acceptance, so a test accepted in the
// next cycle already sees the new row.
// Reset clears the matrix to zero, which makes every box visible, and
// empties the pipeline. When the receiver stalls, the stages fill up and
// s_axis_tready falls once the first stage cannot move on.
// ---------------------------------------------------------------------------
module frustum_aabb_cull_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // row_index[1:0], row_col0..3, box_min_x/y/z, box_max_x/y/z, zero fill
    input  logic [327:0] s_axis_tdata,
    // cmd
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // visible, zero fill
    output logic [7:0]   m_axis_tdata,
    // was_test
    output logic         m_axis_tuser
);
    import fac_pkg::*;

    elem_t mat_reg [16];
    logic  s1_v_reg;
    logic  s1_test_reg;
    coef_t s1_n_reg [NUM_PLANES][4];
    elem_t s1_p_reg [NUM_PLANES][NUM_CORNER_AXES];
    logic  s2_v_reg;
    logic  s2_test_reg;
    logic  out_v_reg;
    logic  out_test_reg;
    logic  out_vis_reg;

    logic  s1_load;
    logic  s2_load;
    logic  out_load;
    logic  [NUM_PLANES-1:0] plane_neg;
    logic  [1:0] row_sel;
    elem_t lo [NUM_CORNER_AXES];
    elem_t hi [NUM_CORNER_AXES];
    coef_t n_next [NUM_PLANES][4];
    elem_t p_next [NUM_PLANES][NUM_CORNER_AXES];

    assign row_sel = s_axis_tdata[1:0];

    always_comb
    begin
        for (int c = 0; c < NUM_CORNER_AXES; c++)
        begin
            lo[c] = s_axis_tdata[2 + 32*(4 + c) +: 32];
            hi[c] = s_axis_tdata[2 + 32*(7 + c) +: 32];
        end
        for (int k = 0; k < NUM_PLANES; k++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                n_next[k][c] = plane_coef(3'(k), mat_reg[c], mat_reg[4 + c],
                                          mat_reg[8 + c], mat_reg[12 + c]);
            end
            for (int c = 0; c < NUM_CORNER_AXES; c++)
            begin
                if (n_next[k][c][COEF_W-1] == 1'b0)
                begin
                    p_next[k][c] = (lo[c] > hi[c]) ? lo[c] : hi[c];
                end
                else
                begin
                    p_next[k][c] = (lo[c] > hi[c]) ? hi[c] : lo[c];
                end
            end
        end
    end

    assign out_load = s2_v_reg && (!out_v_reg || m_axis_tready);
    assign s2_load = s1_v_reg && (!s2_v_reg || out_load);
    assign s_axis_tready = !s1_v_reg || s2_load;
    assign s1_load = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                mat_reg[i] <= '0;
            end
        end
        else if (s1_load && s_axis_tuser == CMD_LOAD)
        begin
            for (int c = 0; c < 4; c++)
            begin
                mat_reg[{row_sel, 2'(c)}] <= s_axis_tdata[2 + 32*c +: 32];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
                s1_v_reg <= 1'b1;
            else if (s2_load)
                s1_v_reg <= 1'b0;
            if (s2_load)
                s2_v_reg <= 1'b1;
            else if (out_load)
                s2_v_reg <= 1'b0;
            if (out_load)
                out_v_reg <= 1'b1;
            else if (m_axis_tready)
                out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_test_reg <= (s_axis_tuser == CMD_TEST);
            s1_n_reg    <= n_next;
            s1_p_reg    <= p_next;
        end
        if (s2_load)
        begin
            s2_test_reg <= s1_test_reg;
        end
        if (out_load)
        begin
            out_test_reg <= s2_test_reg;
            out_vis_reg  <= s2_test_reg && !(|plane_neg);
        end
    end

    for (genvar k = 0; k < NUM_PLANES; k++)
    begin : g_plane
        fac_plane u_plane (
            .clk (clk),
            .en  (s2_load),
            .n_x (s1_n_reg[k][0]),
            .n_y (s1_n_reg[k][1]),
            .n_z (s1_n_reg[k][2]),
            .d   (s1_n_reg[k][3]),
            .p_x (s1_p_reg[k][0]),
            .p_y (s1_p_reg[k][1]),
            .p_z (s1_p_reg[k][2]),
            .neg (plane_neg[k])
        );
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tuser  = out_test_reg;
    assign m_axis_tdata  = {7'b0, out_vis_reg};

`include "frustum_aabb_cull_core_assert.svh"

    `FAC_ASSERT_SAME(a_load_not_visible, m_axis_tvalid && !m_axis_tuser, !m_axis_tdata[0], "load acknowledge marked visible")
    `FAC_ASSERT_SAME(a_stall_only_full, !s_axis_tready, s1_v_reg && s2_v_reg && out_v_reg, "input stalled with a free stage")
    `FAC_ASSERT_NEXT(a_result_held, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "response dropped while stalled")
    `FAC_ASSERT_NEXT(a_s2_fed, s2_load, s2_v_reg, "stage two lost a request")

endmodule

[rtl/fac_plane.sv]
// ---------------------------------------------------------------------------
// Frustum box cull plane evaluator
// Registers the three products of one plane and flags a negative best corner.
// ---------------------------------------------------------------------------
module fac_plane (
    input  logic          clk,
    input  logic          en,
    input  fac_pkg::coef_t n_x,
    input  fac_pkg::coef_t n_y,
    input  fac_pkg::coef_t n_z,
    input  fac_pkg::coef_t d,
    input  fac_pkg::elem_t p_x,
    input  fac_pkg::elem_t p_y,
    input  fac_pkg::elem_t p_z,
    output logic          neg
);
    import fac_pkg::*;

    prod_t prod_x_reg;
    prod_t prod_y_reg;
    prod_t prod_z_reg;
    coef_t d_reg;
    sum_t  sum;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_x_reg <= PROD_W'(n_x * p_x);
            prod_y_reg <= PROD_W'(n_y * p_y);
            prod_z_reg <= PROD_W'(n_z * p_z);
            d_reg      <= d;
        end
    end

    always_comb
    begin
        sum = SUM_W'(prod_x_reg) + SUM_W'(prod_y_reg) + SUM_W'(prod_z_reg)
            + (SUM_W'(d_reg) <<< FRAC_BITS);
        neg = sum[SUM_W-1];
    end

endmodule

[dv/frustum_aabb_cull_core_test.sv]
// ---------------------------------------------------------------------------
// Frustum box culling core testbench
// Loads view-projection rows and sends box tests. A directed table comes
// first, then random requests; every response is checked in order against
// a local prediction of the six-plane test.
// ---------------------------------------------------------------------------
module frustum_aabb_cull_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import fac_pkg::*;

    localparam int STALL_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_REQS = 1000;
    localparam logic [31:0] ONE = 32'h0001_0000;

    typedef struct packed {
        logic                  cmd;
        logic [1:0]            row;
        logic [3:0][ELEM_W-1:0] col;
        logic [2:0][ELEM_W-1:0] bmin;
        logic [2:0][ELEM_W-1:0] bmax;
        logic                  typed;
        logic                  typed_vis;
    } request_t;

    typedef struct packed {
        logic was_test;
        logic visible;
    } response_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [327:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [7:0]   m_axis_tdata;
    logic         m_axis_tuser;

    frustum_aabb_cull_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    logic signed [ELEM_W-1:0] view_proj [4][4];
    response_t pending_responses[$];
    request_t  directed_reqs[$];
    int        errors;
    int        cycles;
    int        send_idle_pct;
    int        recv_idle_pct;
    logic      hold_request;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic box_visible(request_t rq);
        logic signed [127:0] coef [4];
        logic signed [127:0] sum;
        logic signed [127:0] pt;
        int negs;
        int oth;
        int w3;
        int sg;
        for (int k = 0; k < NUM_PLANES; k++)
        begin
            oth = k / 2;
            w3 = (k == 4) ? 0 : 1;
            sg = (k % 2 == 0) ? 1 : -1;
            for (int c = 0; c < 4; c++)
            begin
                coef[c] = (w3 != 0) ? 128'(view_proj[3][c]) : 128'sd0;
                if (sg > 0)
                    coef[c] = coef[c] + 128'(view_proj[oth][c]);
                else
                    coef[c] = coef[c] - 128'(view_proj[oth][c]);
            end
            negs = 0;
            for (int j = 0; j < 8; j++)
            begin
                sum = coef[3] <<< FRAC_BITS;
                for (int c = 0; c < 3; c++)
                begin
                    pt = ((j >> c) & 1) ? 128'($signed(rq.bmax[c]))
                                        : 128'($signed(rq.bmin[c]));
                    sum = sum + coef[c] * pt;
                end
                if (sum < 0)
                    negs++;
            end
            if (negs == 8)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic response_t predict_response(request_t rq);
        response_t r;
        if (rq.cmd == CMD_LOAD)
        begin
            for (int c = 0; c < 4; c++)
                view_proj[rq.row][c] = rq.col[c];
            r.was_test = 1'b0;
            r.visible = 1'b0;
        end
        else
        begin
            r.was_test = 1'b1;
            r.visible = box_visible(rq);
        end
        if (rq.typed)
            r.visible = rq.typed_vis;
        return r;
    endfunction

    function automatic logic [31:0] rand_elem();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return $urandom();
        else if (pick == 1)
            return (pick == 1 && $urandom_range(1)) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            return 32'($signed($urandom_range(8 * ONE)) - $signed(4 * ONE));
    endfunction

    function automatic request_t mk_load(logic [1:0] row, logic [31:0] a, logic [31:0] b,
                                         logic [31:0] c, logic [31:0] d);
        request_t rq;
        rq = '0;
        rq.cmd = CMD_LOAD;
        rq.row = row;
        rq.col = {d, c, b, a};
        rq.typed = 1'b1;
        rq.bmin = {$urandom(), $urandom(), $urandom()};
        return rq;
    endfunction

    function automatic request_t mk_test(logic [31:0] x0, logic [31:0] y0, logic [31:0] z0,
                                         logic [31:0] x1, logic [31:0] y1, logic [31:0] z1,
                                         logic typed, logic vis);
        request_t rq;
        rq = '0;
        rq.cmd = CMD_TEST;
        rq.row = 2'($urandom());
        rq.col = {$urandom(), $urandom(), $urandom(), $urandom()};
        rq.bmin = {z0, y0, x0};
        rq.bmax = {z1, y1, x1};
        rq.typed = typed;
        rq.typed_vis = vis;
        return rq;
    endfunction

    task automatic send_request(request_t rq);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= rq.cmd;
        s_axis_tdata <= {6'b0, rq.bmax, rq.bmin, rq.col, rq.row};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_responses.push_back(predict_response(rq));
    endtask

    initial
    begin
        hold_request = 1'b0;
        m_axis_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                repeat (STALL_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        response_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_responses.size() == 0)
            begin
                $error("response with nothing pending");
                errors++;
            end
            else
            begin
                want = pending_responses.pop_front();
                if (m_axis_tuser !== want.was_test)
                begin
                    $error("was_test expected %0b actual %0b", want.was_test, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata !== {7'b0, want.visible})
                begin
                    $error("visible expected %0b actual %0b", want.visible, m_axis_tdata[0]);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        request_t rq;
        int wait_cycles;
        errors = 0;
        cycles = 0;
        send_idle_pct = 11;
        recv_idle_pct = 74;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = 1'b0;
        s_axis_tdata = '0;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                view_proj[r][c] = '0;

        // Empty matrix: every box is visible, even swapped or extreme bounds; then extreme rows load.
        directed_reqs.push_back(mk_test(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1));
        directed_reqs.push_back(mk_test(32'h7FFF_FFFF, 0, 32'h7FFF_FFFF,
                                        32'h8000_0000, 0, 32'h8000_0000, 1, 1));
        directed_reqs.push_back(mk_load(0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0));
        directed_reqs.push_back(mk_load(1, 32'h7FFF_FFFF, 32'h8000_0000, 0, 32'hFFFF_FFFF));
        directed_reqs.push_back(mk_load(2, 32'hFFFF_FFFF, 0, 32'h8000_0000, 32'h7FFF_FFFF));
        directed_reqs.push_back(mk_load(3, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                        32'h8000_0000));
        directed_reqs.push_back(mk_test(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0));
        directed_reqs.push_back(mk_test(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0));
        directed_reqs.push_back(mk_test(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0));
        // Identity matrix: frustum is -1..1 in x and y, 0..1 in z.
        directed_reqs.push_back(mk_load(0, ONE, 0, 0, 0));
        directed_reqs.push_back(mk_load(1, 0, ONE, 0, 0));
        directed_reqs.push_back(mk_load(2, 0, 0, ONE, 0));
        directed_reqs.push_back(mk_load(3, 0, 0, 0, ONE));
        directed_reqs.push_back(mk_test(0, 0, 0, ONE / 2, ONE / 2, ONE / 2, 1, 1));
        directed_reqs.push_back(mk_test(2 * ONE, 0, 0, 3 * ONE, ONE / 2, ONE / 2, 1, 0));
        directed_reqs.push_back(mk_test(3 * ONE, ONE / 2, ONE / 2, 2 * ONE, 0, 0, 1, 0));
        directed_reqs.push_back(mk_test(0, 0, -ONE, ONE / 2, ONE / 2, -(ONE / 2), 1, 0));
        directed_reqs.push_back(mk_test(0, -3 * ONE, 0, ONE / 2, -2 * ONE, ONE / 2, 1, 0));
        directed_reqs.push_back(mk_test(0, 0, 2 * ONE, ONE / 2, ONE / 2, 3 * ONE, 1, 0));
        directed_reqs.push_back(mk_test(ONE, 0, 0, ONE, ONE / 2, ONE / 2, 1, 1));
        directed_reqs.push_back(mk_test(ONE + 1, 0, 0, ONE + 1, ONE / 2, ONE / 2, 1, 0));
        directed_reqs.push_back(mk_test(0, 0, 0, 0, 0, 0, 1, 1));
        directed_reqs.push_back(mk_test(-5 * ONE, -5 * ONE, -5 * ONE,
                                        5 * ONE, 5 * ONE, 5 * ONE, 1, 1));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_reqs[i])
            send_request(directed_reqs[i]);

        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            if (n == RANDOM_REQS / 3)
            begin
                send_idle_pct = 74;
                recv_idle_pct = 11;
            end
            if (n == 2 * RANDOM_REQS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_request = 1'b1;
            end
            if (n == RANDOM_REQS / 2)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                wait (pending_responses.size() == 0);
            end
            rq = '0;
            rq.cmd = ($urandom_range(3) == 0) ? CMD_LOAD : CMD_TEST;
            rq.row = 2'($urandom());
            for (int c = 0; c < 4; c++)
                rq.col[c] = rand_elem();
            for (int c = 0; c < 3; c++)
            begin
                rq.bmin[c] = rand_elem();
                rq.bmax[c] = ($urandom_range(3) == 0) ? rand_elem()
                             : rq.bmin[c] + $urandom_range(2 * ONE);
            end
            send_request(rq);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b0;

        wait_cycles = 0;
        while (pending_responses.size() != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (10) @(posedge clk);
        if (errors == 0 && pending_responses.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/fac_pkg.sv
rtl/fac_plane.sv
rtl/frustum_aabb_cull_core.sv
dv/frustum_aabb_cull_core_test.sv
